>>> src/cbst_pkg.sv
// ----------------------------------------------------------------------------
// cbst_pkg
// Shared widths, register codes and pipeline types of the cubic Bezier
// stroke tessellator.
// ----------------------------------------------------------------------------
package cbst_pkg;

  localparam int COORD_W   = 32;
  localparam int NRM_W     = 16;
  localparam int STEP_W    = 5;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam logic [STEP_W-1:0]    STEP_RESET     = 5'd16;
  localparam logic [REG_IDX_W-1:0] REG_STEP_COUNT = 1'b0;

  localparam int SQ_W     = 2 * STEP_W;
  localparam int CUBE_W   = 3 * STEP_W;
  localparam int WT_W     = CUBE_W + 2;
  localparam int EW_W     = SQ_W + 1;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int SUM_W    = 48;
  localparam int DV_W     = 44;
  localparam int MAG_W    = 42;
  localparam int PNUM_W   = SUM_W - 1;
  localparam int NSH_W    = 64;
  localparam int NSH_STG  = 6;
  localparam int NORM_TOP = 30;
  localparam int ROOT_W   = 31;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int ONE_SH   = 14;
  localparam int QNUM_W   = NORM_TOP + ONE_SH + 1;
  localparam int QUO_NW   = 15;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    logic signed [DV_W-1:0] dv_x;
    logic signed [DV_W-1:0] dv_y;
    logic                   neg_x;
    logic                   neg_y;
    logic                   last;
  } tag1_t;

  typedef struct packed {
    logic [NORM_TOP-1:0] a;
    logic [NORM_TOP-1:0] b;
    coord_t              pos_x;
    coord_t              pos_y;
    logic                flip_x;
    logic                flip_y;
    logic                degen;
    logic                last;
  } tag2_t;

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    logic   flip_x;
    logic   flip_y;
    logic   degen;
    logic   last;
  } tag3_t;

endpackage

>>> src/cbst_div.sv
// ----------------------------------------------------------------------------
// cbst_div
// Pipelined restoring divider: two numerators over one shared denominator,
// one quotient bit per stage, with a side tag that travels along.
// ----------------------------------------------------------------------------
module cbst_div #(
  parameter int NUM_W = cbst_pkg::PNUM_W,
  parameter int DEN_W = cbst_pkg::CUBE_W,
  parameter int QUO_W = cbst_pkg::COORD_W,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num_a,
  input  logic [NUM_W-1:0] num_b,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] tag_in,
  output logic             out_valid,
  output logic [QUO_W-1:0] quo_a,
  output logic [QUO_W-1:0] quo_b,
  output logic [TAG_W-1:0] tag_out
);

  localparam int CW = NUM_W + QUO_W;

  logic             vld   [QUO_W];
  logic [NUM_W-1:0] rem_a [QUO_W];
  logic [NUM_W-1:0] rem_b [QUO_W];
  logic [QUO_W-1:0] qa    [QUO_W];
  logic [QUO_W-1:0] qb    [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic [TAG_W-1:0] tag_r [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int K = QUO_W - 1 - s;
    logic             v_in;
    logic [NUM_W-1:0] ra_in, rb_in;
    logic [QUO_W-1:0] qa_in, qb_in;
    logic [DEN_W-1:0] d_in;
    logic [TAG_W-1:0] t_in;
    logic [CW-1:0]    dsh;
    logic             ge_a, ge_b;

    if (s == 0) begin : g_first
      assign v_in  = in_valid;
      assign ra_in = num_a;
      assign rb_in = num_b;
      assign qa_in = '0;
      assign qb_in = '0;
      assign d_in  = den;
      assign t_in  = tag_in;
    end else begin : g_next
      assign v_in  = vld[s-1];
      assign ra_in = rem_a[s-1];
      assign rb_in = rem_b[s-1];
      assign qa_in = qa[s-1];
      assign qb_in = qb[s-1];
      assign d_in  = den_r[s-1];
      assign t_in  = tag_r[s-1];
    end

    assign dsh  = CW'(d_in) << K;
    assign ge_a = CW'(ra_in) >= dsh;
    assign ge_b = CW'(rb_in) >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_a[s] <= ge_a ? NUM_W'(CW'(ra_in) - dsh) : ra_in;
        rem_b[s] <= ge_b ? NUM_W'(CW'(rb_in) - dsh) : rb_in;
        qa[s]    <= qa_in | (QUO_W'(ge_a) << K);
        qb[s]    <= qb_in | (QUO_W'(ge_b) << K);
        den_r[s] <= d_in;
        tag_r[s] <= t_in;
      end
    end
  end

  assign out_valid = vld[QUO_W-1];
  assign quo_a     = qa[QUO_W-1];
  assign quo_b     = qb[QUO_W-1];
  assign tag_out   = tag_r[QUO_W-1];

endmodule

>>> src/cbst_sqrt.sv
// ----------------------------------------------------------------------------
// cbst_sqrt
// Pipelined integer square root, one root bit per stage, floor result,
// with a side tag that travels along.
// ----------------------------------------------------------------------------
module cbst_sqrt #(
  parameter int ROOT_W = cbst_pkg::ROOT_W,
  parameter int TAG_W  = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2*ROOT_W-1:0]   radicand,
  input  logic [TAG_W-1:0]      tag_in,
  output logic                  out_valid,
  output logic [ROOT_W-1:0]     root,
  output logic [TAG_W-1:0]      tag_out
);

  localparam int X_W = 2 * ROOT_W;

  logic              vld   [ROOT_W];
  logic [X_W-1:0]    rem   [ROOT_W];
  logic [ROOT_W-1:0] rt    [ROOT_W];
  logic [TAG_W-1:0]  tag_r [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    localparam int K = ROOT_W - 1 - s;
    logic              v_in;
    logic [X_W-1:0]    r_in;
    logic [ROOT_W-1:0] rt_in;
    logic [TAG_W-1:0]  t_in;
    logic [X_W-1:0]    trial;
    logic              ge;

    if (s == 0) begin : g_first
      assign v_in  = in_valid;
      assign r_in  = radicand;
      assign rt_in = '0;
      assign t_in  = tag_in;
    end else begin : g_next
      assign v_in  = vld[s-1];
      assign r_in  = rem[s-1];
      assign rt_in = rt[s-1];
      assign t_in  = tag_r[s-1];
    end

    assign trial = (X_W'(rt_in) << (K + 1)) | (X_W'(1) << (2 * K));
    assign ge    = r_in >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s]   <= ge ? (r_in - trial) : r_in;
        rt[s]    <= rt_in | (ROOT_W'(ge) << K);
        tag_r[s] <= t_in;
      end
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign root      = rt[ROOT_W-1];
  assign tag_out   = tag_r[ROOT_W-1];

endmodule

>>> src/cubic_bezier_stroke_tessellator.sv
// ----------------------------------------------------------------------------
// cubic_bezier_stroke_tessellator
// Samples a cubic Bezier segment and emits a pair of stroke vertices with
// position and unit normal for every sample.
// ----------------------------------------------------------------------------
// A segment of n intervals (step_count, 0 taken as 1) yields 2*(n+1) output
// items (34 at the reset value of 16), one per cycle while out_ready is high.
// The sample generator issues one sample into the pipeline each time the
// output register takes a new sample, and the next segment is accepted as
// the last sample of the current one is issued. A sample passes through the
// position divider, the normalize shifter, the square root and the normal
// divider; the dividers and the square root are pipelined one bit per stage.
// ----------------------------------------------------------------------------
module cubic_bezier_stroke_tessellator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cbst_pkg::ADDR_W-1:0]    paddr,
  input  logic [cbst_pkg::DATA_W-1:0]    pwdata,
  output logic [cbst_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [cbst_pkg::COORD_W-1:0] p0_x,
  input  logic signed [cbst_pkg::COORD_W-1:0] p0_y,
  input  logic signed [cbst_pkg::COORD_W-1:0] p1_x,
  input  logic signed [cbst_pkg::COORD_W-1:0] p1_y,
  input  logic signed [cbst_pkg::COORD_W-1:0] p2_x,
  input  logic signed [cbst_pkg::COORD_W-1:0] p2_y,
  input  logic signed [cbst_pkg::COORD_W-1:0] p3_x,
  input  logic signed [cbst_pkg::COORD_W-1:0] p3_y,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [cbst_pkg::COORD_W-1:0] pos_x,
  output logic signed [cbst_pkg::COORD_W-1:0] pos_y,
  output logic signed [cbst_pkg::NRM_W-1:0]   normal_x,
  output logic signed [cbst_pkg::NRM_W-1:0]   normal_y,
  output logic                           side,
  output logic                           degenerate,
  output logic                           last
);

  import cbst_pkg::*;

  // Configuration.
  logic [STEP_W-1:0] step_count;
  logic [STEP_W-1:0] nn;
  logic [SQ_W-1:0]   n2;
  logic [CUBE_W-1:0] n3;

  assign pready = 1'b1;
  assign prdata = DATA_W'(step_count);
  assign nn     = (step_count == '0) ? STEP_W'(1) : step_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= STEP_RESET;
    end else if (psel && penable && pwrite
                 && paddr[ADDR_W-1:2] == REG_STEP_COUNT) begin
      step_count <= pwdata[STEP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    n2 <= SQ_W'(nn * nn);
    n3 <= CUBE_W'(n2 * nn);
  end

  logic adv;

  // Sample generator.
  logic               busy;
  logic [STEP_W-1:0]  idx;
  point_t [3:0]       pts;
  logic               gen_last;

  assign gen_last = idx == nn;
  assign in_ready = !busy || (adv && gen_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_valid && in_ready) begin
      busy <= 1'b1;
    end else if (adv && gen_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      idx <= '0;
      pts <= {{p3_x, p3_y}, {p2_x, p2_y}, {p1_x, p1_y}, {p0_x, p0_y}};
    end else if (adv && busy) begin
      idx <= idx + STEP_W'(1);
    end
  end

  // Stage 1: sample index and its complement.
  logic              s1_v, s1_last;
  logic [STEP_W-1:0] s1_i, s1_u;
  point_t [3:0]      s1_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_i    <= idx;
      s1_u    <= nn - idx;
      s1_last <= gen_last;
      s1_p    <= pts;
    end
  end

  // Stage 2: squares and control point differences.
  logic                     s2_v, s2_last;
  logic [STEP_W-1:0]        s2_i, s2_u;
  logic [SQ_W-1:0]          s2_u2, s2_i2, s2_iu;
  point_t [3:0]             s2_p;
  logic signed [DIFF_W-1:0] s2_dx [3];
  logic signed [DIFF_W-1:0] s2_dy [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_last <= s1_last;
      s2_i    <= s1_i;
      s2_u    <= s1_u;
      s2_u2   <= SQ_W'(s1_u * s1_u);
      s2_i2   <= SQ_W'(s1_i * s1_i);
      s2_iu   <= SQ_W'(s1_i * s1_u);
      s2_p    <= s1_p;
      for (int k = 0; k < 3; k++) begin
        s2_dx[k] <= DIFF_W'(s1_p[k+1].x) - DIFF_W'(s1_p[k].x);
        s2_dy[k] <= DIFF_W'(s1_p[k+1].y) - DIFF_W'(s1_p[k].y);
      end
    end
  end

  // Stage 3: Bernstein weights.
  logic                     s3_v, s3_last;
  logic [WT_W-1:0]          s3_w [4];
  logic [EW_W-1:0]          s3_e [3];
  point_t [3:0]             s3_p;
  logic signed [DIFF_W-1:0] s3_dx [3];
  logic signed [DIFF_W-1:0] s3_dy [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (adv) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_last <= s2_last;
      s3_w[0] <= WT_W'(s2_u2 * s2_u);
      s3_w[1] <= WT_W'(2'd3 * s2_iu * s2_u);
      s3_w[2] <= WT_W'(2'd3 * s2_iu * s2_i);
      s3_w[3] <= WT_W'(s2_i2 * s2_i);
      s3_e[0] <= EW_W'(s2_u2);
      s3_e[1] <= {s2_iu, 1'b0};
      s3_e[2] <= EW_W'(s2_i2);
      s3_p    <= s2_p;
      s3_dx   <= s2_dx;
      s3_dy   <= s2_dy;
    end
  end

  // Stage 4: weighted products.
  logic                   s4_v, s4_last;
  logic signed [SUM_W-1:0] s4_px [4];
  logic signed [SUM_W-1:0] s4_py [4];
  logic signed [DV_W-1:0]  s4_ex [3];
  logic signed [DV_W-1:0]  s4_ey [3];

  for (genvar k = 0; k < 4; k++) begin : g_wprod
    logic signed [WT_W+COORD_W:0] mx, my;
    assign mx = $signed({1'b0, s3_w[k]}) * s3_p[k].x;
    assign my = $signed({1'b0, s3_w[k]}) * s3_p[k].y;
    always_ff @(posedge clk) begin
      if (adv) begin
        s4_px[k] <= SUM_W'(mx);
        s4_py[k] <= SUM_W'(my);
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_eprod
    logic signed [EW_W+DIFF_W:0] mx, my;
    assign mx = $signed({1'b0, s3_e[k]}) * s3_dx[k];
    assign my = $signed({1'b0, s3_e[k]}) * s3_dy[k];
    always_ff @(posedge clk) begin
      if (adv) begin
        s4_ex[k] <= DV_W'(mx);
        s4_ey[k] <= DV_W'(my);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (adv) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_last <= s3_last;
    end
  end

  // Stage 5: sums.
  logic                    s5_v, s5_last;
  logic signed [SUM_W-1:0] s5_sx, s5_sy;
  logic signed [DV_W-1:0]  s5_dvx, s5_dvy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (adv) begin
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_last <= s4_last;
      s5_sx   <= s4_px[0] + s4_px[1] + s4_px[2] + s4_px[3];
      s5_sy   <= s4_py[0] + s4_py[1] + s4_py[2] + s4_py[3];
      s5_dvx  <= s4_ex[0] + s4_ex[1] + s4_ex[2];
      s5_dvy  <= s4_ey[0] + s4_ey[1] + s4_ey[2];
    end
  end

  // Stage 6: magnitude plus half the divisor for round half away from zero.
  logic                    s6_v;
  logic [PNUM_W-1:0]       s6_nx, s6_ny;
  tag1_t                   s6_tag;
  logic signed [SUM_W-1:0] half;

  assign half = SUM_W'(n3 >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (adv) begin
      s6_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_nx        <= PNUM_W'(s5_sx[SUM_W-1] ? (half - s5_sx) : (s5_sx + half));
      s6_ny        <= PNUM_W'(s5_sy[SUM_W-1] ? (half - s5_sy) : (s5_sy + half));
      s6_tag.dv_x  <= s5_dvx;
      s6_tag.dv_y  <= s5_dvy;
      s6_tag.neg_x <= s5_sx[SUM_W-1];
      s6_tag.neg_y <= s5_sy[SUM_W-1];
      s6_tag.last  <= s5_last;
    end
  end

  // Position divider.
  logic               d1_v;
  logic [COORD_W-1:0] d1_qx, d1_qy;
  tag1_t              d1_tag;

  cbst_div #(
    .NUM_W (PNUM_W),
    .DEN_W (CUBE_W),
    .QUO_W (COORD_W),
    .TAG_W ($bits(tag1_t))
  ) u_pos_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s6_v),
    .num_a     (s6_nx),
    .num_b     (s6_ny),
    .den       (n3),
    .tag_in    (s6_tag),
    .out_valid (d1_v),
    .quo_a     (d1_qx),
    .quo_b     (d1_qy),
    .tag_out   (d1_tag)
  );

  // Normal stage A: signed position, derivative magnitudes.
  logic               na_v, na_flip_x, na_flip_y, na_last;
  coord_t             na_pos_x, na_pos_y;
  logic [MAG_W-1:0]   na_ax, na_ay;

  always_ff @(posedge clk) begin
    if (rst) begin
      na_v <= 1'b0;
    end else if (adv) begin
      na_v <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      na_pos_x  <= d1_tag.neg_x ? -d1_qx : d1_qx;
      na_pos_y  <= d1_tag.neg_y ? -d1_qy : d1_qy;
      na_ax     <= MAG_W'(d1_tag.dv_x[DV_W-1] ? -d1_tag.dv_x : d1_tag.dv_x);
      na_ay     <= MAG_W'(d1_tag.dv_y[DV_W-1] ? -d1_tag.dv_y : d1_tag.dv_y);
      na_flip_x <= d1_tag.dv_y > 0;
      na_flip_y <= d1_tag.dv_x[DV_W-1];
      na_last   <= d1_tag.last;
    end
  end

  // Normal stage B: larger magnitude.
  logic             nb_v;
  logic [NSH_W-1:0] nb_m, nb_a, nb_b;
  tag3_t            nb_tag;
  logic [MAG_W-1:0] nb_max;

  assign nb_max = (na_ax > na_ay) ? na_ax : na_ay;

  always_ff @(posedge clk) begin
    if (rst) begin
      nb_v <= 1'b0;
    end else if (adv) begin
      nb_v <= na_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nb_m          <= NSH_W'(nb_max);
      nb_a          <= NSH_W'(na_ax);
      nb_b          <= NSH_W'(na_ay);
      nb_tag.pos_x  <= na_pos_x;
      nb_tag.pos_y  <= na_pos_y;
      nb_tag.flip_x <= na_flip_x;
      nb_tag.flip_y <= na_flip_y;
      nb_tag.degen  <= nb_max == '0;
      nb_tag.last   <= na_last;
    end
  end

  // Normalize shifter: left shifts of 32, 16, 8, 4, 2, 1 driven by the
  // larger magnitude until its top bit sits in the most significant place.
  logic             sh_v   [NSH_STG];
  logic [NSH_W-1:0] sh_m   [NSH_STG];
  logic [NSH_W-1:0] sh_a   [NSH_STG];
  logic [NSH_W-1:0] sh_b   [NSH_STG];
  tag3_t            sh_tag [NSH_STG];

  for (genvar s = 0; s < NSH_STG; s++) begin : g_norm
    localparam int SH = 1 << (NSH_STG - 1 - s);
    logic             v_in, hit;
    logic [NSH_W-1:0] m_in, a_in, b_in;
    tag3_t            t_in;

    if (s == 0) begin : g_first
      assign v_in = nb_v;
      assign m_in = nb_m;
      assign a_in = nb_a;
      assign b_in = nb_b;
      assign t_in = nb_tag;
    end else begin : g_next
      assign v_in = sh_v[s-1];
      assign m_in = sh_m[s-1];
      assign a_in = sh_a[s-1];
      assign b_in = sh_b[s-1];
      assign t_in = sh_tag[s-1];
    end

    assign hit = m_in[NSH_W-1 -: SH] == '0;

    always_ff @(posedge clk) begin
      if (rst) begin
        sh_v[s] <= 1'b0;
      end else if (adv) begin
        sh_v[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sh_m[s]   <= hit ? (m_in << SH) : m_in;
        sh_a[s]   <= hit ? (a_in << SH) : a_in;
        sh_b[s]   <= hit ? (b_in << SH) : b_in;
        sh_tag[s] <= t_in;
      end
    end
  end

  // Squares of the normalized magnitudes.
  logic                  sq_v;
  logic [NORM_TOP-1:0]   sq_a, sq_b;
  logic [2*NORM_TOP-1:0] sq_a2, sq_b2;
  tag3_t                 sq_tag;
  logic [NORM_TOP-1:0]   top_a, top_b;

  assign top_a = sh_a[NSH_STG-1][NSH_W-1 -: NORM_TOP];
  assign top_b = sh_b[NSH_STG-1][NSH_W-1 -: NORM_TOP];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v <= 1'b0;
    end else if (adv) begin
      sq_v <= sh_v[NSH_STG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_a   <= top_a;
      sq_b   <= top_b;
      sq_a2  <= top_a * top_a;
      sq_b2  <= top_b * top_b;
      sq_tag <= sh_tag[NSH_STG-1];
    end
  end

  // Sum of squares.
  logic             ss_v;
  logic [RAD_W-1:0] ss_x;
  tag2_t            ss_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      ss_v <= 1'b0;
    end else if (adv) begin
      ss_v <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ss_x          <= RAD_W'(sq_a2) + RAD_W'(sq_b2);
      ss_tag.a      <= sq_a;
      ss_tag.b      <= sq_b;
      ss_tag.pos_x  <= sq_tag.pos_x;
      ss_tag.pos_y  <= sq_tag.pos_y;
      ss_tag.flip_x <= sq_tag.flip_x;
      ss_tag.flip_y <= sq_tag.flip_y;
      ss_tag.degen  <= sq_tag.degen;
      ss_tag.last   <= sq_tag.last;
    end
  end

  logic              rt_v;
  logic [ROOT_W-1:0] rt_r;
  tag2_t             rt_tag;

  cbst_sqrt #(
    .ROOT_W (ROOT_W),
    .TAG_W  ($bits(tag2_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (ss_v),
    .radicand  (ss_x),
    .tag_in    (ss_tag),
    .out_valid (rt_v),
    .root      (rt_r),
    .tag_out   (rt_tag)
  );

  // Normal divider numerators, rounded to nearest.
  logic              qn_v;
  logic [QNUM_W-1:0] qn_a, qn_b;
  logic [ROOT_W-1:0] qn_r;
  tag3_t             qn_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      qn_v <= 1'b0;
    end else if (adv) begin
      qn_v <= rt_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qn_a          <= QNUM_W'({rt_tag.a, ONE_SH'(0)}) + QNUM_W'(rt_r >> 1);
      qn_b          <= QNUM_W'({rt_tag.b, ONE_SH'(0)}) + QNUM_W'(rt_r >> 1);
      qn_r          <= rt_r;
      qn_tag.pos_x  <= rt_tag.pos_x;
      qn_tag.pos_y  <= rt_tag.pos_y;
      qn_tag.flip_x <= rt_tag.flip_x;
      qn_tag.flip_y <= rt_tag.flip_y;
      qn_tag.degen  <= rt_tag.degen;
      qn_tag.last   <= rt_tag.last;
    end
  end

  logic              d2_v;
  logic [QUO_NW-1:0] d2_qa, d2_qb;
  tag3_t             d2_tag;

  cbst_div #(
    .NUM_W (QNUM_W),
    .DEN_W (ROOT_W),
    .QUO_W (QUO_NW),
    .TAG_W ($bits(tag3_t))
  ) u_nrm_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (qn_v),
    .num_a     (qn_a),
    .num_b     (qn_b),
    .den       (qn_r),
    .tag_in    (qn_tag),
    .out_valid (d2_v),
    .quo_a     (d2_qa),
    .quo_b     (d2_qb),
    .tag_out   (d2_tag)
  );

  // Output register: one sample, shown as two vertices.
  logic signed [NRM_W-1:0] nx_mag, ny_mag;
  logic signed [NRM_W-1:0] o_nx, o_ny;
  logic                    o_last;

  assign nx_mag = NRM_W'(d2_qb);
  assign ny_mag = NRM_W'(d2_qa);
  assign adv    = !out_valid || (side && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      side      <= 1'b0;
    end else if (adv) begin
      out_valid <= d2_v;
      side      <= 1'b0;
    end else if (out_ready) begin
      side      <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_x      <= d2_tag.pos_x;
      pos_y      <= d2_tag.pos_y;
      degenerate <= d2_tag.degen;
      o_last     <= d2_tag.last;
      o_nx       <= d2_tag.degen ? '0 : (d2_tag.flip_x ? -nx_mag : nx_mag);
      o_ny       <= d2_tag.degen ? '0 : (d2_tag.flip_y ? -ny_mag : ny_mag);
    end
  end

  assign normal_x = side ? -o_nx : o_nx;
  assign normal_y = side ? -o_ny : o_ny;
  assign last     = o_last && side;

  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !side |=> out_valid && side && $stable(pos_x)
      && $stable(pos_y))
    else $error("companion vertex did not follow the first vertex");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> normal_x == '0 && normal_y == '0)
    else $error("degenerate sample with nonzero normal");

  a_normal_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate |-> normal_x != '0 || normal_y != '0)
    else $error("regular sample with zero normal");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    busy && adv && gen_last && !(in_valid && in_ready) |=> !busy)
    else $error("generator kept running after the final sample");

endmodule
